FILE: rtl/ppws_pkg.sv
// shared types and constants for the preemptive priority work scheduler
`default_nettype none
package ppws_pkg;

    localparam int JOB_SLOTS_DEF     = 64;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int PRIO_IN_BITS      = 16;
    localparam int UNIT_BITS         = 16;
    localparam int COST_BITS         = 40;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic found_free;
        logic found_best;
    } scan_flags_t;

endpackage
`default_nettype wire

FILE: rtl/preemptive_priority_work_scheduler.sv
// top level of the preemptive priority work scheduler
// one item at a time: the next input is taken only after the slot scan through the job memory and the update
// a result waiting on the output does not block the next input transfer or its scan
// reset: a clearing pass writes zero to every job memory slot, s_ready stays low meanwhile
`default_nettype none
module preemptive_priority_work_scheduler #(
    parameter int JOB_SLOTS     = ppws_pkg::JOB_SLOTS_DEF,
    parameter int PRIORITY_BITS = ppws_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_cmd,
    input  wire logic [ppws_pkg::PRIO_IN_BITS-1:0]    s_priority_req,
    input  wire logic [ppws_pkg::UNIT_BITS-1:0]       s_work_units,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [ppws_pkg::COST_BITS-1:0]       m_pending_cost,
    output logic                                      m_served,
    output logic      [ppws_pkg::PRIO_IN_BITS-1:0]    m_served_priority,
    output logic                                      m_dropped
);
    import ppws_pkg::*;

    localparam int AW      = $clog2(JOB_SLOTS);
    localparam int CNT_W   = AW + 1;
    localparam int ENTRY_W = PRIORITY_BITS + UNIT_BITS;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     cnt_last;
    logic                     cmd_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [UNIT_BITS-1:0]     units_reg;
    logic [ENTRY_W-1:0]       product_reg;
    logic [COST_BITS-1:0]     cost_reg;
    logic [COST_BITS-1:0]     cost_next;
    logic                     m_valid_reg;
    logic [COST_BITS-1:0]     m_cost_reg;
    logic                     m_served_reg;
    logic [PRIO_IN_BITS-1:0]  m_sprio_reg;
    logic                     m_dropped_reg;

    logic [31:0]              prio_wide;
    logic [PRIORITY_BITS-1:0] prio_in;
    logic [63:0]              product_wide;
    logic [31:0]              best_prio_wide;
    logic                     accept;
    logic                     out_free;
    logic                     commit;
    logic                     scan_issue;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [ENTRY_W-1:0]       mem_wdata;
    logic [ENTRY_W-1:0]       mem_rdata;

    logic                     upd_we;
    logic [AW-1:0]            upd_addr;
    logic [ENTRY_W-1:0]       upd_data;
    logic                     served_n;
    logic [PRIO_IN_BITS-1:0]  sprio_n;
    logic                     dropped_n;

    scan_flags_t              flags;
    logic [AW-1:0]            free_idx;
    logic [AW-1:0]            best_idx;
    logic [PRIORITY_BITS-1:0] best_prio;
    logic [UNIT_BITS-1:0]     best_rem;

    assign prio_wide      = 32'(s_priority_req);
    assign prio_in        = prio_wide[PRIORITY_BITS-1:0];
    assign product_wide   = 64'(product_reg);
    assign best_prio_wide = 32'(best_prio);
    assign cnt_last       = (cnt_reg == CNT_W'(JOB_SLOTS - 1));
    assign accept         = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;

    ppws_job_ram #(
        .DEPTH (JOB_SLOTS),
        .WIDTH (ENTRY_W),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (scan_issue),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    ppws_scan #(
        .AW            (AW),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .issue     (scan_issue),
        .issue_idx (cnt_reg[AW-1:0]),
        .rd_prio   (mem_rdata[ENTRY_W-1:UNIT_BITS]),
        .rd_rem    (mem_rdata[UNIT_BITS-1:0]),
        .flags     (flags),
        .free_idx  (free_idx),
        .best_idx  (best_idx),
        .best_prio (best_prio),
        .best_rem  (best_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready    = 1'b0;
        scan_issue = 1'b0;
        commit     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg[AW-1:0];
        mem_wdata  = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                scan_issue = 1'b1;
            end
            ST_UPDATE: begin
                commit    = out_free;
                mem_we    = out_free && upd_we;
                mem_waddr = upd_addr;
                mem_wdata = upd_data;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // entry update and result for the item under service
    always_comb begin
        upd_we    = 1'b0;
        upd_addr  = free_idx;
        upd_data  = {prio_reg, units_reg};
        cost_next = cost_reg;
        served_n  = 1'b0;
        sprio_n   = '0;
        dropped_n = 1'b0;
        if (cmd_reg == CMD_ARRIVAL) begin
            if (units_reg != '0) begin
                if (flags.found_free) begin
                    upd_we    = 1'b1;
                    cost_next = cost_reg + product_wide[COST_BITS-1:0];
                end else begin
                    dropped_n = 1'b1;
                end
            end
        end else if (flags.found_best) begin
            upd_we    = 1'b1;
            upd_addr  = best_idx;
            upd_data  = {best_prio, best_rem - UNIT_BITS'(1)};
            cost_next = cost_reg - COST_BITS'(best_prio);
            served_n  = 1'b1;
            sprio_n   = best_prio_wide[PRIO_IN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            cost_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept || (state_reg == ST_CLEAR && cnt_last)) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_CLEAR || state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (commit) begin
                cost_reg    <= cost_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= s_cmd;
            prio_reg    <= prio_in;
            units_reg   <= s_work_units;
            product_reg <= ENTRY_W'(prio_in) * ENTRY_W'(s_work_units);
        end
        if (commit) begin
            m_cost_reg    <= cost_next;
            m_served_reg  <= served_n;
            m_sprio_reg   <= sprio_n;
            m_dropped_reg <= dropped_n;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pending_cost    = m_cost_reg;
    assign m_served          = m_served_reg;
    assign m_served_priority = m_sprio_reg;
    assign m_dropped         = m_dropped_reg;

endmodule
`default_nettype wire

FILE: rtl/ppws_job_ram.sv
// job table memory, one write port and one registered read port
`default_nettype none
module ppws_job_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ppws_scan.sv
// running search for the first free slot and the highest priority live job
`default_nettype none
module ppws_scan #(
    parameter int AW            = 6,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic                                issue,
    input  wire logic [AW-1:0]                       issue_idx,
    input  wire logic [PRIORITY_BITS-1:0]            rd_prio,
    input  wire logic [ppws_pkg::UNIT_BITS-1:0]      rd_rem,
    output ppws_pkg::scan_flags_t                    flags,
    output logic      [AW-1:0]                       free_idx,
    output logic      [AW-1:0]                       best_idx,
    output logic      [PRIORITY_BITS-1:0]            best_prio,
    output logic      [ppws_pkg::UNIT_BITS-1:0]      best_rem
);
    import ppws_pkg::*;

    logic                     pend_reg;
    logic [AW-1:0]            pend_idx_reg;
    scan_flags_t              flags_reg;
    logic [AW-1:0]            free_idx_reg;
    logic [AW-1:0]            best_idx_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic [UNIT_BITS-1:0]     best_rem_reg;
    logic                     hit_free;
    logic                     hit_best;

    assign hit_free = pend_reg && (rd_rem == '0) && !flags_reg.found_free;
    assign hit_best = pend_reg && (rd_rem != '0)
                      && (!flags_reg.found_best || (rd_prio > best_prio_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            flags_reg <= '0;
        end else if (start) begin
            pend_reg  <= 1'b0;
            flags_reg <= '0;
        end else begin
            pend_reg <= issue;
            if (hit_free) begin
                flags_reg.found_free <= 1'b1;
            end
            if (hit_best) begin
                flags_reg.found_best <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= issue_idx;
        if (hit_free) begin
            free_idx_reg <= pend_idx_reg;
        end
        if (hit_best) begin
            best_idx_reg  <= pend_idx_reg;
            best_prio_reg <= rd_prio;
            best_rem_reg  <= rd_rem;
        end
    end

    assign flags     = flags_reg;
    assign free_idx  = free_idx_reg;
    assign best_idx  = best_idx_reg;
    assign best_prio = best_prio_reg;
    assign best_rem  = best_rem_reg;

endmodule
`default_nettype wire
